### hw/rtl/memory_ring_frame_sync_unit_defines.svh
// Assertion macros for the memory ring frame sync unit.
// Included by the top-level RTL file, which carries concurrent assertions; no other dependencies.
`ifndef MEMORY_RING_FRAME_SYNC_UNIT_DEFINES_SVH
`define MEMORY_RING_FRAME_SYNC_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MRFS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mrfs assertion failed");

// Next-cycle implication, disabled during reset.
`define MRFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mrfs assertion failed");

`endif

### hw/rtl/mrfs_pkg.sv
// Shared constants, codes and helpers for the memory ring frame sync unit.
// No dependencies.
`default_nettype none

package mrfs_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 315;
  localparam int unsigned RING_SLOTS_DEF  = 16;

  localparam logic [1:0] SYNC_HUNT = 2'd0;
  localparam logic [1:0] SYNC_WAIT = 2'd1;
  localparam logic [1:0] SYNC_LOCK = 2'd2;

  localparam logic [1:0] WSEQ_IDLE = 2'd0;
  localparam logic [1:0] WSEQ_INIT = 2'd1;
  localparam logic [1:0] WSEQ_BUSY = 2'd2;

  // Mark search window: 13 bytes preceding the current one.
  localparam int unsigned WINDOW_LEN   = 13;
  localparam int unsigned HUNT_MIN_POS = 15;
  localparam int unsigned RESUME_POS   = 15;
  localparam int unsigned MARK_LO_CNT  = 5;
  localparam int unsigned MARK_HI_CNT  = 4;

  // Command nibbles: even tetrad takes the high nibble, odd tetrad the low nibble.
  localparam int unsigned CMD_HI_TETRAD = 25 * 3 + 1;
  localparam int unsigned CMD_LO_TETRAD = 24 * 3 + 1;
  localparam int unsigned CMD_HI_POS    = CMD_HI_TETRAD / 2;
  localparam int unsigned CMD_LO_POS    = CMD_LO_TETRAD / 2;

  localparam logic [3:0] NIB_ONES = 4'hF;

  function automatic logic [7:0] swap_nib(input logic [7:0] v);
    swap_nib = {v[3:0], v[7:4]};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mrfs_ram.sv
// Generic single-write, single-read RAM with registered, enabled read port.
// No dependencies.
`default_nettype none

module mrfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 315
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/memory_ring_frame_sync_unit.sv
// Memory ring frame sync unit: top level.
// Depends on mrfs_pkg, mrfs_ram and memory_ring_frame_sync_unit_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one raw ring byte plus a
//   write-pass request per transaction. Output channel (out_valid/out_ready)
//   returns exactly one result transaction per input transaction, in order.
//   Each accepted byte is inverted, nibble-swapped and stored in the frame
//   RAM; the mark search, wrap check, command capture and write sequencer
//   all resolve in the accept cycle and land in the output register.
//   The result is registered and valid in the cycle after the input is accepted.
//   Throughput: one transaction per cycle while out_ready stays high; the frame RAM serves the echo
//   read and the store write in the same cycle on separate ports.
//   Stall: while a result waits and out_ready is low, in_ready is low and
//   all state and the output payload hold; in_ready rises in the cycle the
//   result is taken, so a new byte enters as the old result leaves.
//   Reset (rst, synchronous, active high): hunting, position zero, sequencer
//   idle, command slot zero, newest command zero, output empty. The frame
//   RAM is not cleared; tx_byte is forced to zero whenever tx_valid is low.
`default_nettype none
`include "memory_ring_frame_sync_unit_defines.svh"

module memory_ring_frame_sync_unit #(
  parameter int unsigned FRAME_BYTES = mrfs_pkg::FRAME_BYTES_DEF,
  parameter int unsigned RING_SLOTS  = mrfs_pkg::RING_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     rx_byte,
  input  wire logic                           start_write,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                tx_valid,
  output logic                                tx_from_dump,
  output logic [$clog2(FRAME_BYTES)-1:0]      tx_index,
  output logic [7:0]                          tx_byte,
  output logic                                skip_clock,
  output logic                                mk_write_on,
  output logic                                command_valid,
  output logic [7:0]                          command_code,
  output logic [$clog2(RING_SLOTS)-1:0]       command_slot,
  output logic [1:0]                          sync_state,
  output logic                                frame_start
);

  import mrfs_pkg::*;

  localparam int unsigned PW = $clog2(FRAME_BYTES);
  localparam int unsigned SW = $clog2(RING_SLOTS);

  logic          accept;

  logic [PW-1:0] pos;
  logic [1:0]    mode;
  logic [7:0]    bcnt;
  logic [1:0]    wseq;
  logic [SW-1:0] head;
  logic [7:0]    last_code;
  logic [7:0]    win [WINDOW_LEN];
  logic [3:0]    mark_lo [MARK_LO_CNT];
  logic [3:0]    mark_hi [MARK_HI_CNT];
  logic [3:0]    cmd_hi;
  logic [3:0]    cmd_lo;

  logic [PW-1:0] pos_next;
  logic [1:0]    mode_next;
  logic [7:0]    bcnt_next;
  logic [1:0]    wseq_req;
  logic [1:0]    wseq_next;
  logic [SW-1:0] head_next;
  logic [7:0]    code_next;

  logic [7:0]    conv;
  logic          locked;
  logic          last_pos;
  logic [PW-1:0] tx_idx;
  logic          win_mark;
  logic          head_mark;
  logic          hunt_hit;
  logic [7:0]    cmd_now;
  logic          skip;
  logic          cmd_new;

  logic [7:0]    ram_rdata;

  assign accept   = in_valid && in_ready;
  assign in_ready = !rst && (!out_valid || out_ready);

  always_comb begin
    conv     = swap_nib(~rx_byte);
    locked   = (mode == SYNC_LOCK);
    last_pos = (pos == PW'(FRAME_BYTES - 1));
    tx_idx   = last_pos ? '0 : pos + 1'b1;
    wseq_req = (start_write && wseq == WSEQ_IDLE) ? WSEQ_INIT : wseq;

    win_mark = (&{win[12][3:0], win[9][3:0], win[6][3:0], win[3][3:0], win[0][3:0]})
            && (&{win[10][7:4], win[7][7:4], win[4][7:4], win[1][7:4]});
    head_mark = 1'b1;
    for (int i = 0; i < MARK_LO_CNT; i++) begin
      head_mark = head_mark && (mark_lo[i] == NIB_ONES);
    end
    for (int i = 0; i < MARK_HI_CNT; i++) begin
      head_mark = head_mark && (mark_hi[i] == NIB_ONES);
    end
    cmd_now = {cmd_hi, cmd_lo};

    pos_next  = pos + 1'b1;
    mode_next = mode;
    bcnt_next = bcnt + 8'd1;
    wseq_next = wseq_req;
    head_next = head;
    code_next = last_code;
    skip      = 1'b0;
    cmd_new   = 1'b0;
    hunt_hit  = 1'b0;

    if (mode == SYNC_HUNT && pos >= PW'(HUNT_MIN_POS)) begin
      if (win_mark) begin
        hunt_hit  = 1'b1;
        pos_next  = PW'(RESUME_POS);
        mode_next = SYNC_WAIT;
      end else if (bcnt_next == 8'd0) begin
        skip = 1'b1;
      end
    end

    if (last_pos && !hunt_hit) begin
      pos_next = '0;
      if (head_mark) begin
        mode_next = SYNC_LOCK;
        if (last_code != cmd_now) begin
          head_next = (head == SW'(RING_SLOTS - 1)) ? '0 : head + 1'b1;
          code_next = cmd_now;
          cmd_new   = 1'b1;
        end
        if (wseq_req == WSEQ_BUSY) begin
          wseq_next = WSEQ_IDLE;
        end else if (wseq_req == WSEQ_INIT) begin
          wseq_next = WSEQ_BUSY;
        end
      end else begin
        if (mode == SYNC_LOCK) begin
          mode_next = SYNC_HUNT;
        end
        skip = 1'b1;
      end
    end
  end

  mrfs_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (pos),
    .wdata (conv),
    .re    (accept),
    .raddr (tx_idx),
    .rdata (ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      mode      <= SYNC_HUNT;
      bcnt      <= '0;
      wseq      <= WSEQ_IDLE;
      head      <= '0;
      last_code <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos       <= pos_next;
        mode      <= mode_next;
        bcnt      <= bcnt_next;
        wseq      <= wseq_next;
        head      <= head_next;
        last_code <= code_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Window taps, mark shadows and command nibbles.
  always_ff @(posedge clk) begin
    if (accept) begin
      win[0] <= conv;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        win[i] <= win[i-1];
      end
      for (int i = 0; i < MARK_LO_CNT; i++) begin
        if (pos == PW'(3 * i)) begin
          mark_lo[i] <= conv[3:0];
        end
      end
      for (int i = 0; i < MARK_HI_CNT; i++) begin
        if (pos == PW'(3 * i + 2)) begin
          mark_hi[i] <= conv[7:4];
        end
      end
      if (pos == PW'(CMD_HI_POS)) begin
        cmd_hi <= conv[7:4];
      end
      if (pos == PW'(CMD_LO_POS)) begin
        cmd_lo <= conv[3:0];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      tx_valid      <= locked;
      tx_from_dump  <= locked && (wseq_req == WSEQ_BUSY);
      tx_index      <= locked ? tx_idx : '0;
      skip_clock    <= skip;
      mk_write_on   <= (wseq_next == WSEQ_BUSY);
      command_valid <= cmd_new;
      frame_start   <= (pos == '0);
    end
  end

  assign tx_byte      = tx_valid ? swap_nib(ram_rdata) : 8'd0;
  assign command_code = last_code;
  assign command_slot = head;
  assign sync_state   = mode;

  `MRFS_ASSERT_NOW(a_cmd_only_locked, clk, rst, out_valid && command_valid, sync_state == SYNC_LOCK)
  `MRFS_ASSERT_NEXT(a_wait_never_hunts, clk, rst, accept && mode == SYNC_WAIT, mode != SYNC_HUNT)
  `MRFS_ASSERT_NEXT(a_head_moves_on_cmd, clk, rst, accept, command_valid || head == $past(head))
  `MRFS_ASSERT_NEXT(a_stall_holds_state, clk, rst, out_valid && !out_ready, $stable(pos) && $stable(mode))

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking bench for memory_ring_frame_sync_unit: drives ring bytes with write
// requests, predicts every echo/sync report in-line and compares each transaction.
// Depends on mrfs_pkg and the memory_ring_frame_sync_unit RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrfs_pkg::*;

  localparam int unsigned FRAME        = FRAME_BYTES_DEF;
  localparam int unsigned MARK_SPAN    = 14;
  localparam int unsigned RANDOM_ITEMS = 620;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic       tx_valid;
    logic       tx_from_dump;
    logic [8:0] tx_index;
    logic [7:0] tx_byte;
    logic       skip_clock;
    logic       mk_write_on;
    logic       command_valid;
    logic [7:0] command_code;
    logic [3:0] command_slot;
    logic [1:0] sync_state;
    logic       frame_start;
  } sync_report_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       sw;
    logic       fstart;
    logic [1:0] sync;
  } opening_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       start_write = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       tx_valid;
  logic       tx_from_dump;
  logic [8:0] tx_index;
  logic [7:0] tx_byte;
  logic       skip_clock;
  logic       mk_write_on;
  logic       command_valid;
  logic [7:0] command_code;
  logic [3:0] command_slot;
  logic [1:0] sync_state;
  logic       frame_start;

  sync_report_t sync_reports[$];
  opening_row_t opening [16];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;

  // Frame tracker state
  logic [7:0]  ring_image [FRAME];
  int unsigned ring_pos = 0;
  logic [1:0]  ring_mode = SYNC_HUNT;
  logic [7:0]  byte_tick = 8'h00;
  logic [1:0]  write_phase = WSEQ_IDLE;
  logic [7:0]  cmd_hist [16];
  logic [3:0]  cmd_head = 4'd0;

  memory_ring_frame_sync_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .start_write  (start_write),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tx_valid     (tx_valid),
    .tx_from_dump (tx_from_dump),
    .tx_index     (tx_index),
    .tx_byte      (tx_byte),
    .skip_clock   (skip_clock),
    .mk_write_on  (mk_write_on),
    .command_valid(command_valid),
    .command_code (command_code),
    .command_slot (command_slot),
    .sync_state   (sync_state),
    .frame_start  (frame_start)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic logic mark_ok(input int unsigned b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = ring_image[b % FRAME] & ring_image[(b + 3) % FRAME] & ring_image[(b + 6) % FRAME]
       & ring_image[(b + 9) % FRAME] & ring_image[(b + 12) % FRAME] & 8'h0F;
    hi = ring_image[(b + 2) % FRAME] & ring_image[(b + 5) % FRAME]
       & ring_image[(b + 8) % FRAME] & ring_image[(b + 11) % FRAME] & 8'hF0;
    return (lo | hi) == 8'hFF;
  endfunction

  task automatic advance_ring(input logic [7:0] raw, input logic req, output sync_report_t r);
    logic [7:0]  code;
    logic [7:0]  hi_src;
    logic [7:0]  lo_src;
    logic [7:0]  inv;
    int unsigned nxt;
    r = '0;
    if (req && write_phase == WSEQ_IDLE) write_phase = WSEQ_INIT;
    if (ring_mode == SYNC_LOCK) begin
      nxt            = (ring_pos + 1) % FRAME;
      r.tx_valid     = 1'b1;
      r.tx_from_dump = (write_phase == WSEQ_BUSY);
      r.tx_index     = nxt[8:0];
      r.tx_byte      = {ring_image[nxt][3:0], ring_image[nxt][7:4]};
    end
    r.frame_start = (ring_pos == 0);
    byte_tick = byte_tick + 8'd1;
    inv = ~raw;
    ring_image[ring_pos] = {inv[3:0], inv[7:4]};
    ring_pos++;
    if (ring_mode == SYNC_HUNT && ring_pos > HUNT_MIN_POS) begin
      if (mark_ok(ring_pos - MARK_SPAN)) begin
        ring_pos  = RESUME_POS;
        ring_mode = SYNC_WAIT;
      end else if (byte_tick == 8'h00) begin
        r.skip_clock = 1'b1;
      end
    end
    if (ring_pos >= FRAME) begin
      ring_pos = 0;
      if (mark_ok(0)) begin
        ring_mode = SYNC_LOCK;
        hi_src = ring_image[CMD_HI_POS];
        lo_src = ring_image[CMD_LO_POS];
        code   = {hi_src[7:4], lo_src[3:0]};
        if (cmd_hist[cmd_head] != code) begin
          cmd_head = cmd_head + 4'd1;
          cmd_hist[cmd_head] = code;
          r.command_valid = 1'b1;
        end
        if (write_phase == WSEQ_BUSY) write_phase = WSEQ_IDLE;
        else if (write_phase == WSEQ_INIT) write_phase = WSEQ_BUSY;
      end else begin
        if (ring_mode == SYNC_LOCK) ring_mode = SYNC_HUNT;
        r.skip_clock = 1'b1;
      end
    end
    r.mk_write_on  = (write_phase == WSEQ_BUSY);
    r.command_code = cmd_hist[cmd_head];
    r.command_slot = cmd_head;
    r.sync_state   = ring_mode;
  endtask

  function automatic logic [7:0] mark_mask(input int unsigned base, input int unsigned p);
    int unsigned off;
    off = p - base;
    if (p < base || off > 12) return 8'h00;
    if (off % 3 == 0) return 8'h0F;
    if (off % 3 == 2) return 8'hF0;
    return 8'h00;
  endfunction

  // Build the raw byte for the next position; mark-friendly unless noise is set.
  function automatic logic [7:0] next_raw(input bit noise);
    logic [7:0] s;
    logic       ones;
    s = 8'($urandom);
    if (!noise) begin
      s = s | mark_mask(0, ring_pos);
      if (ring_mode == SYNC_HUNT) s = s | mark_mask(2, ring_pos);
      ones = 1'($urandom_range(0, 1));
      if (ring_pos == CMD_HI_POS && $urandom_range(0, 3) != 0) s[7:4] = {4{ones}};
      if (ring_pos == CMD_LO_POS && $urandom_range(0, 3) != 0) s[3:0] = {4{ones}};
    end
    return ~{s[3:0], s[7:4]};
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic w, output sync_report_t r);
    in_valid    <= 1'b1;
    rx_byte     <= b;
    start_write <= w;
    do @(posedge clk); while (!in_ready);
    advance_ring(b, w, r);
  endtask

  task automatic note_mismatch(input string field, input logic [8:0] want, input logic [8:0] got);
    $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    mismatches++;
  endtask

  task automatic compare_report(input sync_report_t want, input sync_report_t got);
    if (got.tx_valid !== want.tx_valid)
      note_mismatch("tx_valid", want.tx_valid, got.tx_valid);
    if (got.tx_from_dump !== want.tx_from_dump)
      note_mismatch("tx_from_dump", want.tx_from_dump, got.tx_from_dump);
    if (got.tx_index !== want.tx_index)
      note_mismatch("tx_index", want.tx_index, got.tx_index);
    if (got.tx_byte !== want.tx_byte)
      note_mismatch("tx_byte", want.tx_byte, got.tx_byte);
    if (got.skip_clock !== want.skip_clock)
      note_mismatch("skip_clock", want.skip_clock, got.skip_clock);
    if (got.mk_write_on !== want.mk_write_on)
      note_mismatch("mk_write_on", want.mk_write_on, got.mk_write_on);
    if (got.command_valid !== want.command_valid)
      note_mismatch("command_valid", want.command_valid, got.command_valid);
    if (got.command_code !== want.command_code)
      note_mismatch("command_code", want.command_code, got.command_code);
    if (got.command_slot !== want.command_slot)
      note_mismatch("command_slot", want.command_slot, got.command_slot);
    if (got.sync_state !== want.sync_state)
      note_mismatch("sync_state", want.sync_state, got.sync_state);
    if (got.frame_start !== want.frame_start)
      note_mismatch("frame_start", want.frame_start, got.frame_start);
  endtask

  always @(posedge clk) begin : result_monitor
    sync_report_t want;
    sync_report_t got;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      got = {tx_valid, tx_from_dump, tx_index, tx_byte, skip_clock, mk_write_on,
             command_valid, command_code, command_slot, sync_state, frame_start};
      if (sync_reports.size() == 0) begin
        $display("%0t: unexpected transaction, expected none actual %0h", $time, got);
        mismatches++;
      end else begin
        want = sync_reports.pop_front();
        compare_report(want, got);
      end
    end
  end

  always @(posedge clk) begin : stall_pattern
    int unsigned stall_mode;
    int unsigned stall_left;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(8, 64);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("[memory_ring_frame_sync_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    sync_report_t r;
    int unsigned  sent;
    int unsigned  burst;
    int unsigned  gap;
    bit           noise;
    logic [7:0]   b;
    logic         w;
    foreach (cmd_hist[i]) cmd_hist[i] = 8'h00;
    foreach (ring_image[i]) ring_image[i] = 8'h00;
    // All-zero raw bytes store as 0xFF and form the mark at base two.
    foreach (opening[i]) opening[i] = {8'h00, 1'b0, 1'b0, SYNC_HUNT};
    opening[0]  = {8'h00, 1'b1, 1'b1, SYNC_HUNT};
    opening[1]  = {8'hFF, 1'b0, 1'b0, SYNC_HUNT};
    opening[3]  = {8'h00, 1'b1, 1'b0, SYNC_HUNT};
    opening[15] = {8'hA5, 1'b1, 1'b0, SYNC_WAIT};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (opening[i]) begin
      put_byte(opening[i].rx, opening[i].sw, r);
      r = '0;
      r.frame_start = opening[i].fstart;
      r.sync_state  = opening[i].sync;
      sync_reports.push_back(r);
    end
    in_valid <= 1'b0;
    while (sync_reports.size() != 0) @(posedge clk);
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      noise = ($urandom_range(0, 3) == 0);
      repeat (burst) begin
        w = ($urandom_range(0, 15) == 0);
        b = next_raw(noise);
        put_byte(b, w, r);
        sync_reports.push_back(r);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        while (sync_reports.size() != 0) @(posedge clk);
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
    while (sync_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("[memory_ring_frame_sync_unit] OK");
    else $display("[memory_ring_frame_sync_unit] ERROR");
    $finish;
  end

endmodule
